// ===== hdl/cbfr_pkg.sv =====
package cbfr_pkg;

   // build-time defaults for the top-level parameters
   localparam int DEF_MAX_COLUMNS = 128;
   localparam int DEF_MAX_ROWS    = 16;

   // fixed field widths
   localparam int XIN_W  = 7;
   localparam int YIN_W  = 4;
   localparam int CSR_W  = 8;
   localparam int CNT_W  = 4;
   localparam int REP_N  = 8;

   // register reset values
   localparam logic [7:0] WIDTH_RST  = 8'd112;
   localparam logic [4:0] HEIGHT_RST = 5'd16;

   typedef enum logic [1:0] {
      OP_PIXEL   = 2'd0,
      OP_CLEAR   = 2'd1,
      OP_REFRESH = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_UPSIDE = 2'd2,
      CSR_UNUSED = 2'd3
   } csr_type;

   localparam logic [7:0] HEADER_REP [REP_N] =
      '{8'h1D, 8'h06, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] TRAILER_REP [REP_N] =
      '{8'h01, 8'h05, 8'h03, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00};

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(REP_N);

endpackage

// ===== hdl/column_byte_framebuffer_refresh_top.sv =====
// 1-bit-per-pixel frame store kept as column bytes in pages of eight rows
// (top row of a page in the msb), with a report-stream refresh. An item is
// taken when start is high and busy is low; for a pixel write or a refresh
// busy then stays high until the item is finished. A pixel write goes
// through latch, address + ram read, then read-modify-write; a clear is done
// in the accept cycle with busy staying low, since the store is cleared by
// dropping one valid bit per byte, and a cleared byte reads as zero. Code 3
// does nothing and leaves busy low. A refresh sends a header report, then the
// first floor(w*h/8) store bytes in reports of up to eight bytes, then a
// trailer report with rsp_last_report high. The single ram read port sets
// the refresh pace: one byte per cycle while a data report is read, then a
// drain state and an emit state for each data report. Each report sits on
// the rsp_ ports for exactly one cycle, flagged by rsp_strobe; the receiver
// cannot stall it. There is no clearing pass after reset. Register writes
// are not gated by busy: write them only while the block is idle.
module column_byte_framebuffer_refresh_top
   import cbfr_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic                 clock,
   input  logic                 reset,
   // command side
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_operation,
   input  logic [XIN_W-1:0]     req_pixel_x,
   input  logic [YIN_W-1:0]     req_pixel_y,
   input  logic                 req_pixel_on,
   // report side
   output logic                 rsp_strobe,
   output logic [7:0]           rsp_byte0,
   output logic [7:0]           rsp_byte1,
   output logic [7:0]           rsp_byte2,
   output logic [7:0]           rsp_byte3,
   output logic [7:0]           rsp_byte4,
   output logic [7:0]           rsp_byte5,
   output logic [7:0]           rsp_byte6,
   output logic [7:0]           rsp_byte7,
   output logic [CNT_W-1:0]     rsp_byte_count,
   output logic                 rsp_last_report,
   // register writes
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   // store geometry
   localparam int PAGES       = (MAX_ROWS + 7) / 8;
   localparam int STORE_DEPTH = MAX_COLUMNS * PAGES;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int PW          = AW + 1;                  // address with headroom
   localparam int SW          = $clog2(STORE_DEPTH + 1); // byte index / size
   localparam int WW          = $clog2(MAX_COLUMNS + 1); // effective width
   localparam int HW          = $clog2(MAX_ROWS + 1);    // effective height
   localparam int XW          = $clog2(MAX_COLUMNS);     // column index
   localparam int YW          = $clog2(MAX_ROWS);        // row index
   localparam int AREA_W      = WW + HW;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_PX_ADDR   = 6'b000010,
      ST_PX_WRITE  = 6'b000100,
      ST_REF_READ  = 6'b001000,
      ST_REF_DRAIN = 6'b010000,
      ST_REF_EMIT  = 6'b100000
   } state_type;

   // config registers
   logic [7:0]          width_ff;
   logic [4:0]          height_ff;
   logic                upside_ff;

   // sequencer and item registers
   state_type           state_ff, state_in;
   logic [XIN_W-1:0]    x_ff, x_in;
   logic [YIN_W-1:0]    y_ff, y_in;
   logic                on_ff, on_in;
   logic [SW-1:0]       size_ff, size_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [7:0]          mask_ff, mask_in;
   logic                hit_ff, hit_in;
   logic [SW-1:0]       rd_idx_ff, rd_idx_in;
   logic [2:0]          lane_ff, lane_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                last_ff, last_in;
   logic                cap_valid_ff, cap_valid_in;
   logic [2:0]          cap_lane_ff, cap_lane_in;
   logic [7:0]          rep_ff [REP_N];
   logic [7:0]          rep_in [REP_N];
   logic [STORE_DEPTH-1:0] valid_ff, valid_in;
   logic                rd_vld_ff;

   // datapath
   logic                accept;
   logic [WW-1:0]       w_eff;
   logic [HW-1:0]       h_eff;
   logic [AREA_W-1:0]   area;
   logic                in_range;
   logic [XW-1:0]       x_m;
   logic [YW-1:0]       y_m;
   logic [PW-1:0]       pos_full;
   logic [AW-1:0]       rd_addr;
   logic [7:0]          ram_q;
   logic [7:0]          rd_byte;
   logic                ram_we;
   logic [7:0]          ram_wdata;

   assign accept = start && !busy;

   // effective sizes saturate at the store limits
   assign w_eff = (width_ff > MAX_COLUMNS) ? WW'(MAX_COLUMNS) : WW'(width_ff);
   assign h_eff = (height_ff > MAX_ROWS) ? HW'(MAX_ROWS) : HW'(height_ff);
   assign area  = AREA_W'(w_eff) * AREA_W'(h_eff);

   // pixel address: range check on raw coordinates, then optional mirror
   assign in_range = (x_ff < w_eff) && (y_ff < h_eff);
   assign x_m = upside_ff ? XW'(w_eff - WW'(1) - WW'(x_ff)) : XW'(x_ff);
   assign y_m = upside_ff ? YW'(h_eff - HW'(1) - HW'(y_ff)) : YW'(y_ff);
   assign pos_full = PW'(y_m >> 3) * PW'(w_eff) + PW'(x_m);

   // one read port shared by pixel read-modify-write and refresh streaming
   assign rd_addr = (state_ff == ST_PX_ADDR) ? pos_full[AW-1:0] : rd_idx_ff[AW-1:0];
   // bytes never written since the last clear read as zero
   assign rd_byte = rd_vld_ff ? ram_q : 8'h00;

   assign ram_we    = (state_ff == ST_PX_WRITE) && hit_ff;
   assign ram_wdata = on_ff ? (rd_byte | mask_ff) : (rd_byte & ~mask_ff);

   cbfr_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // config port
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         upside_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_write_data;
            CSR_HEIGHT: height_ff <= csr_write_data[4:0];
            CSR_UPSIDE: upside_ff <= csr_write_data[0];
            default:    ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      on_in        = on_ff;
      size_in      = size_ff;
      pos_in       = pos_ff;
      mask_in      = mask_ff;
      hit_in       = hit_ff;
      rd_idx_in    = rd_idx_ff;
      lane_in      = lane_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      cap_valid_in = 1'b0;
      cap_lane_in  = lane_ff;
      rep_in       = rep_ff;
      valid_in     = valid_ff;

      // land the byte whose read was issued in the previous cycle
      if (cap_valid_ff) begin
         rep_in[cap_lane_ff] = rd_byte;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in      = req_pixel_x;
               y_in      = req_pixel_y;
               on_in     = req_pixel_on;
               size_in   = SW'(area >> 3);
               rd_idx_in = '0;
               case (req_operation)
                  OP_PIXEL: state_in = ST_PX_ADDR;
                  OP_CLEAR: valid_in = '0;
                  OP_REFRESH: begin
                     rep_in   = HEADER_REP;
                     cnt_in   = FULL_COUNT;
                     last_in  = 1'b0;
                     state_in = ST_REF_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_PX_ADDR: begin
            pos_in   = pos_full[AW-1:0];
            mask_in  = 8'h80 >> y_m[2:0];
            hit_in   = in_range && (pos_full < PW'(STORE_DEPTH));
            state_in = ST_PX_WRITE;
         end
         ST_PX_WRITE: begin
            if (hit_ff) begin
               valid_in[pos_ff] = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_REF_READ: begin
            cap_valid_in = 1'b1;
            cap_lane_in  = lane_ff;
            rd_idx_in    = rd_idx_ff + SW'(1);
            lane_in      = lane_ff + 3'd1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if ((lane_ff == 3'd7) || ((rd_idx_ff + SW'(1)) == size_ff)) begin
               state_in = ST_REF_DRAIN;
            end
         end
         ST_REF_DRAIN: begin
            state_in = ST_REF_EMIT;
         end
         ST_REF_EMIT: begin
            if (last_ff) begin
               state_in = ST_IDLE;
            end else if (rd_idx_ff == size_ff) begin
               rep_in  = TRAILER_REP;
               cnt_in  = FULL_COUNT;
               last_in = 1'b1;
            end else begin
               for (int k = 0; k < REP_N; k++) begin
                  rep_in[k] = 8'h00;
               end
               lane_in  = '0;
               cnt_in   = '0;
               state_in = ST_REF_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         cap_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         cap_valid_ff <= cap_valid_in;
         last_ff      <= last_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      on_ff       <= on_in;
      size_ff     <= size_in;
      pos_ff      <= pos_in;
      mask_ff     <= mask_in;
      hit_ff      <= hit_in;
      rd_idx_ff   <= rd_idx_in;
      lane_ff     <= lane_in;
      cnt_ff      <= cnt_in;
      cap_lane_ff <= cap_lane_in;
      rep_ff      <= rep_in;
      // valid bit follows the ram read address with the same latency
      rd_vld_ff   <= valid_ff[rd_addr];
   end

   // outputs straight from registers
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = (state_ff == ST_REF_EMIT);
   assign rsp_byte0       = rep_ff[0];
   assign rsp_byte1       = rep_ff[1];
   assign rsp_byte2       = rep_ff[2];
   assign rsp_byte3       = rep_ff[3];
   assign rsp_byte4       = rep_ff[4];
   assign rsp_byte5       = rep_ff[5];
   assign rsp_byte6       = rep_ff[6];
   assign rsp_byte7       = rep_ff[7];
   assign rsp_byte_count  = cnt_ff;
   assign rsp_last_report = last_ff;

   // checks
   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_pixel_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req_operation == OP_PIXEL) |=> busy && !rsp_strobe)
      else $error("pixel write did not enter its sequence");

   a_refresh_header: assert property (@(posedge clock) disable iff (reset)
      accept && (req_operation == OP_REFRESH) |=>
         rsp_strobe && !rsp_last_report && (rsp_byte0 == HEADER_REP[0]))
      else $error("refresh did not open with the header report");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_byte_count != '0) && (rsp_byte_count <= FULL_COUNT))
      else $error("report byte count out of range");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_report |=> !busy)
      else $error("trailer report did not end the refresh");

endmodule

// ===== hdl/cbfr_ram.sv =====
module cbfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/refresh_report_checker.sv =====
`timescale 1ns / 1ps

// watches the command, report and register ports, keeps its own frame store
// and checks every report against the oldest one still expected
module refresh_report_checker
   import cbfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_operation,
   input  logic [XIN_W-1:0]  req_pixel_x,
   input  logic [YIN_W-1:0]  req_pixel_y,
   input  logic              req_pixel_on,
   input  logic              rsp_strobe,
   input  logic [7:0]        rsp_byte0,
   input  logic [7:0]        rsp_byte1,
   input  logic [7:0]        rsp_byte2,
   input  logic [7:0]        rsp_byte3,
   input  logic [7:0]        rsp_byte4,
   input  logic [7:0]        rsp_byte5,
   input  logic [7:0]        rsp_byte6,
   input  logic [7:0]        rsp_byte7,
   input  logic [CNT_W-1:0]  rsp_byte_count,
   input  logic              rsp_last_report,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_write_data,
   output int                mismatch_count,
   output int                reports_outstanding
);

   localparam int COLUMNS     = DEF_MAX_COLUMNS;
   localparam int ROWS        = DEF_MAX_ROWS;
   localparam int STORE_BYTES = COLUMNS * ((ROWS + 7) / 8);

   typedef struct packed {
      logic [7:0][7:0]   bytes;
      logic [CNT_W-1:0]  count;
      logic              last;
   } report_type;

   logic [7:0] pixel_store [STORE_BYTES];
   logic [7:0] width_reg;
   logic [4:0] height_reg;
   logic       upside_reg;
   report_type expected_reports [$];

   function automatic int used_width();
      return (int'(width_reg) > COLUMNS) ? COLUMNS : int'(width_reg);
   endfunction

   function automatic int used_height();
      return (int'(height_reg) > ROWS) ? ROWS : int'(height_reg);
   endfunction

   function automatic string report_text(report_type r);
      return $sformatf("%02h %02h %02h %02h %02h %02h %02h %02h count %0d last %0d",
         r.bytes[0], r.bytes[1], r.bytes[2], r.bytes[3],
         r.bytes[4], r.bytes[5], r.bytes[6], r.bytes[7], r.count, r.last);
   endfunction

   // sets or clears one bit; coordinates are range checked before the mirror
   task automatic store_pixel(int x, int y, logic on);
      int      w;
      int      h;
      int      pos;
      logic [7:0] mask;
      w = used_width();
      h = used_height();
      if (x >= w || y >= h) return;
      if (upside_reg) begin
         x = w - 1 - x;
         y = h - 1 - y;
      end
      pos = (y / 8) * w + x;
      if (pos >= STORE_BYTES) return;
      mask = 8'h80 >> (y % 8);
      if (on) pixel_store[pos] = pixel_store[pos] | mask;
      else pixel_store[pos] = pixel_store[pos] & ~mask;
   endtask

   // header, store bytes in groups of eight, trailer
   task automatic queue_refresh_reports();
      int      total;
      int      n;
      report_type r;
      total = (used_width() * used_height()) / 8;
      if (total > STORE_BYTES) total = STORE_BYTES;
      for (int j = 0; j < REP_N; j++) r.bytes[j] = HEADER_REP[j];
      r.count = FULL_COUNT;
      r.last = 1'b0;
      expected_reports.push_back(r);
      for (int i = 0; i < total; i += 8) begin
         n = (total - i > 8) ? 8 : total - i;
         for (int j = 0; j < REP_N; j++) r.bytes[j] = (j < n) ? pixel_store[i + j] : 8'h00;
         r.count = CNT_W'(n);
         r.last = 1'b0;
         expected_reports.push_back(r);
      end
      for (int j = 0; j < REP_N; j++) r.bytes[j] = TRAILER_REP[j];
      r.count = FULL_COUNT;
      r.last = 1'b1;
      expected_reports.push_back(r);
   endtask

   always @(posedge clock) begin
      report_type seen;
      report_type want;
      if (reset) begin
         foreach (pixel_store[i]) pixel_store[i] = 8'h00;
         width_reg = WIDTH_RST;
         height_reg = HEIGHT_RST;
         upside_reg = 1'b0;
         mismatch_count = 0;
         expected_reports.delete();
      end else begin
         if (rsp_strobe) begin
            seen.bytes = {rsp_byte7, rsp_byte6, rsp_byte5, rsp_byte4,
                          rsp_byte3, rsp_byte2, rsp_byte1, rsp_byte0};
            seen.count = rsp_byte_count;
            seen.last = rsp_last_report;
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%t unexpected report: %s", $realtime, report_text(seen));
            end else begin
               want = expected_reports.pop_front();
               if (seen.bytes !== want.bytes || seen.count !== want.count ||
                   seen.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%t report mismatch", $realtime);
                     $display("   expected %s", report_text(want));
                     $display("   actual   %s", report_text(seen));
                  end
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_type'(csr_index))
               CSR_WIDTH:  width_reg = csr_write_data[7:0];
               CSR_HEIGHT: height_reg = csr_write_data[4:0];
               CSR_UPSIDE: upside_reg = csr_write_data[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            case (op_type'(req_operation))
               OP_PIXEL:   store_pixel(int'(req_pixel_x), int'(req_pixel_y), req_pixel_on);
               OP_CLEAR:   foreach (pixel_store[i]) pixel_store[i] = 8'h00;
               OP_REFRESH: queue_refresh_reports();
               default: ;
            endcase
         end
      end
      reports_outstanding = expected_reports.size();
   end

endmodule

// ===== tb/column_byte_framebuffer_refresh_top_test.sv =====
`timescale 1ns / 1ps

// stimulus and verdict for the frame store block; all report checking sits in
// refresh_report_checker
module column_byte_framebuffer_refresh_top_test;
   import cbfr_pkg::*;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 37;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_operation = OP_NONE;
   logic [XIN_W-1:0]  req_pixel_x = '0;
   logic [YIN_W-1:0]  req_pixel_y = '0;
   logic              req_pixel_on = 1'b0;
   logic              rsp_strobe;
   logic [7:0]        rsp_byte0;
   logic [7:0]        rsp_byte1;
   logic [7:0]        rsp_byte2;
   logic [7:0]        rsp_byte3;
   logic [7:0]        rsp_byte4;
   logic [7:0]        rsp_byte5;
   logic [7:0]        rsp_byte6;
   logic [7:0]        rsp_byte7;
   logic [CNT_W-1:0]  rsp_byte_count;
   logic              rsp_last_report;
   logic              csr_write_enable = 1'b0;
   logic [1:0]        csr_index = CSR_WIDTH;
   logic [CSR_W-1:0]  csr_write_data = '0;
   int                mismatch_count;
   int                reports_outstanding;

   // saturated display size as the block sees it, used to aim pixel writes
   int                cur_w = 112;
   int                cur_h = 16;

   always #5 clock = ~clock;

   column_byte_framebuffer_refresh_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_pixel_on     (req_pixel_on),
      .rsp_strobe       (rsp_strobe),
      .rsp_byte0        (rsp_byte0),
      .rsp_byte1        (rsp_byte1),
      .rsp_byte2        (rsp_byte2),
      .rsp_byte3        (rsp_byte3),
      .rsp_byte4        (rsp_byte4),
      .rsp_byte5        (rsp_byte5),
      .rsp_byte6        (rsp_byte6),
      .rsp_byte7        (rsp_byte7),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last_report  (rsp_last_report),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   refresh_report_checker report_check (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_pixel_x         (req_pixel_x),
      .req_pixel_y         (req_pixel_y),
      .req_pixel_on        (req_pixel_on),
      .rsp_strobe          (rsp_strobe),
      .rsp_byte0           (rsp_byte0),
      .rsp_byte1           (rsp_byte1),
      .rsp_byte2           (rsp_byte2),
      .rsp_byte3           (rsp_byte3),
      .rsp_byte4           (rsp_byte4),
      .rsp_byte5           (rsp_byte5),
      .rsp_byte6           (rsp_byte6),
      .rsp_byte7           (rsp_byte7),
      .rsp_byte_count      (rsp_byte_count),
      .rsp_last_report     (rsp_last_report),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .mismatch_count      (mismatch_count),
      .reports_outstanding (reports_outstanding)
   );

   // present one item at the falling edge and hold it until the block takes it;
   // start stays high so back-to-back items need no extra cycle
   task automatic send_item(op_type op, logic [XIN_W-1:0] x, logic [YIN_W-1:0] y,
                            logic on);
      @(negedge clock);
      start <= 1'b1;
      req_operation <= op;
      req_pixel_x <= x;
      req_pixel_y <= y;
      req_pixel_on <= on;
      // busy read right after the edge is the value the block saw
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // drain: every report in, block idle, then a further margin so a
   // trailing pixel write is surely done before any register write
   task automatic wait_quiet();
      @(negedge clock);
      start <= 1'b0;
      while (reports_outstanding != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(csr_type idx, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(int w, int h, logic flip);
      write_reg(CSR_WIDTH, CSR_W'(w));
      write_reg(CSR_HEIGHT, CSR_W'(h));
      write_reg(CSR_UPSIDE, CSR_W'(flip));
      cur_w = (w > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : w;
      cur_h = (h > DEF_MAX_ROWS) ? DEF_MAX_ROWS : h;
   endtask

   // hard stop in case the block hangs
   initial begin
      #6_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int sel;
      int wv;
      int hv;
      int pick;
      logic [XIN_W-1:0] px;
      logic [YIN_W-1:0] py;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, reset size 112 x 16, no mirror
      send_item(OP_PIXEL, 7'd0, 4'd0, 1'b1);           // top-left corner
      send_item(OP_PIXEL, 7'd111, 4'd15, 1'b1);        // bottom-right corner
      send_item(OP_PIXEL, 7'd127, 4'd0, 1'b1);         // x past width, dropped
      send_item(OP_PIXEL, 7'd3, 4'd8, 1'b1);           // first row of second page
      send_item(OP_PIXEL, 7'd64, 4'd7, 1'b1);          // lsb of first page
      send_item(OP_REFRESH, 7'h7F, 4'hF, 1'b1);
      send_item(OP_PIXEL, 7'd0, 4'd0, 1'b0);           // turn a pixel off again
      send_item(OP_NONE, 7'h55, 4'hA, 1'b1);           // unused code, no effect
      send_item(OP_REFRESH, 7'd0, 4'd0, 1'b0);
      wait_quiet();

      // mirrored writes, plus a write to the unused register index
      configure(112, 16, 1'b1);
      write_reg(CSR_UNUSED, 8'hA5);
      send_item(OP_PIXEL, 7'd0, 4'd0, 1'b1);
      send_item(OP_PIXEL, 7'd10, 4'd3, 1'b1);
      send_item(OP_PIXEL, 7'd111, 4'd15, 1'b1);
      send_item(OP_REFRESH, 7'd0, 4'd0, 1'b0);
      send_item(OP_CLEAR, 7'h2A, 4'h5, 1'b0);
      send_item(OP_REFRESH, 7'd0, 4'd0, 1'b0);
      wait_quiet();

      // zero width: writes ignored, refresh is header and trailer only
      configure(0, 16, 1'b0);
      send_item(OP_PIXEL, 7'd0, 4'd0, 1'b1);
      send_item(OP_REFRESH, 7'd0, 4'd0, 1'b0);
      wait_quiet();

      // both sizes over the maximum saturate
      configure(255, 31, 1'b0);
      send_item(OP_PIXEL, 7'd127, 4'd15, 1'b1);
      send_item(OP_PIXEL, 7'd120, 4'd9, 1'b1);
      send_item(OP_REFRESH, 7'd0, 4'd0, 1'b0);
      wait_quiet();

      // partial last page is stored but only whole bytes go out
      configure(20, 12, 1'b1);
      send_item(OP_PIXEL, 7'd0, 4'd0, 1'b1);
      send_item(OP_PIXEL, 7'd5, 4'd11, 1'b1);
      send_item(OP_REFRESH, 7'd0, 4'd0, 1'b0);
      wait_quiet();

      // smallest legal size
      configure(1, 8, 1'b0);
      send_item(OP_PIXEL, 7'd0, 4'd7, 1'b1);
      send_item(OP_REFRESH, 7'd0, 4'd0, 1'b0);

      // random phases, each with its own display setup; most items are
      // in-range pixel writes so refreshes carry real picture content
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_quiet();
         sel = $urandom_range(0, 9);
         if (sel == 0) wv = 0;
         else if (sel == 1) wv = 255;
         else if (sel == 2) wv = 128;
         else if (sel == 3) wv = 1;
         else wv = $urandom_range(1, 128);
         sel = $urandom_range(0, 9);
         if (sel == 0) hv = 0;
         else if (sel == 1) hv = $urandom_range(17, 31);
         else if (sel == 2) hv = $urandom_range(1, 7);
         else hv = $urandom_range(8, 16);
         configure(wv, hv, 1'($urandom_range(0, 1)));

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            px = XIN_W'($urandom);
            py = YIN_W'($urandom);
            if (pick < 65) begin
               // well-formed write inside the display when there is one
               if (cur_w > 0 && cur_h > 0) begin
                  px = XIN_W'($urandom_range(cur_w - 1, 0));
                  py = YIN_W'($urandom_range(cur_h - 1, 0));
               end
               send_item(OP_PIXEL, px, py, 1'($urandom_range(0, 9) < 7));
            end else if (pick < 75) begin
               send_item(OP_PIXEL, px, py, 1'($urandom));
            end else if (pick < 78) begin
               send_item(OP_CLEAR, px, py, 1'($urandom));
            end else if (pick < 80) begin
               send_item(OP_NONE, px, py, 1'($urandom));
            end else begin
               send_item(OP_REFRESH, px, py, 1'($urandom));
            end
            // sender gaps in bursts, none in the last phase
            if (phase < PHASES - 1 && $urandom_range(0, 3) == 0)
               idle_cycles($urandom_range(1, 7));
         end
      end

      wait_quiet();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && reports_outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
